>>> src/cld_pkg.sv
// Package for the canonical line discipline: shared types, character codes and echo helpers.
// No dependencies.
package cld_pkg;

  localparam logic [7:0] ChNl  = 8'h0A;
  localparam logic [7:0] ChCr  = 8'h0D;
  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChBs  = 8'h08;
  localparam logic [7:0] ChSp  = 8'h20;
  localparam logic [7:0] ChCsi = 8'h9B;
  localparam logic [7:0] ChCaret = 8'h5E;
  localparam logic [7:0] ChBrk = 8'h5B;

  localparam logic [2:0] CfgLocal = 3'd0;
  localparam logic [2:0] CfgInput = 3'd1;
  localparam logic [2:0] CfgOutput = 3'd2;
  localparam logic [2:0] CfgSpecA = 3'd3;
  localparam logic [2:0] CfgSpecB = 3'd4;

  localparam logic [1:0] SigNone = 2'd0;
  localparam logic [1:0] SigInt  = 2'd1;
  localparam logic [1:0] SigQuit = 2'd2;
  localparam logic [1:0] SigSusp = 2'd3;

  // Echo text of one item: up to nine bytes and a length.
  typedef struct packed {
    logic [8:0][7:0] bytes;
    logic [3:0]      len;
  } echo_t;

  typedef struct packed {
    logic [7:0] echo_byte;
    logic       echo_valid;
    logic [1:0] signal_code;
    logic       line_ready;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       read_delimiter;
    logic [8:0] queued_count;
    logic       last;
  } res_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] char_in;
  } req_t;

  function automatic echo_t add_byte(echo_t e, logic [7:0] b);
    echo_t r;
    r = e;
    if (r.len < 4'd9) begin
      r.bytes[r.len] = b;
      r.len = r.len + 4'd1;
    end
    return r;
  endfunction

  function automatic echo_t post_out(echo_t e, logic [7:0] c, logic [2:0] of);
    echo_t r;
    r = e;
    if (of[0] && c == ChTab && of[2]) begin
      for (int i = 0; i < 6; i++) r = add_byte(r, ChSp);
    end else if (of[0] && c == ChNl && of[1]) begin
      r = add_byte(r, ChCr);
      r = add_byte(r, ChNl);
    end else begin
      r = add_byte(r, c);
    end
    return r;
  endfunction

  function automatic echo_t echo_char(logic [7:0] c, logic [2:0] of);
    echo_t r;
    r = '0;
    if ((c >= 8'h20 && c < 8'h80) || c == ChNl || c == ChCr || c == ChTab) begin
      r = post_out(r, c, of);
    end else if (c == ChCsi) begin
      r = add_byte(r, ChCaret);
      r = add_byte(r, ChBrk);
      r = add_byte(r, ChBrk);
    end else begin
      r = add_byte(r, ChCaret);
      r = add_byte(r, c + 8'h40);
    end
    return r;
  endfunction

  function automatic echo_t rubout_echo(logic [7:0] c, logic [2:0] of);
    echo_t r;
    logic [1:0] groups;
    r = '0;
    if (c == ChTab) begin
      for (int i = 0; i < 6; i++) r = post_out(r, ChBs, of);
    end else begin
      if (c >= 8'h20 && c < 8'h80) groups = 2'd1;
      else if (c == ChCsi) groups = 2'd3;
      else groups = 2'd2;
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < groups) begin
          r = post_out(r, ChBs, of);
          r = post_out(r, ChSp, of);
          r = post_out(r, ChBs, of);
        end
      end
    end
    return r;
  endfunction

endpackage

>>> src/cld_stream_if.sv
// Valid/ready channel interface carrying one payload item.
// Depends on nothing; payload type is a parameter.
interface cld_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/cld_queue_mem.sv
// Byte queue storage: one synchronous memory, one write and one registered read port.
// A read of the entry written in the same cycle returns the new byte. Depends on nothing.
module cld_queue_mem #(
  parameter int unsigned Depth = 256,
  localparam int unsigned AW = $clog2(Depth)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);
  logic [7:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= (we_i && waddr_i == raddr_i) ? wdata_i : mem_q[raddr_i];
  end
endmodule

>>> src/canonical_line_discipline_unit.sv
// Canonical terminal line discipline, edit and read queues held in two synchronous memories.
// Each accepted item passes the read, decide and emit states in order; a line commit inserts
// the commit state before emit, which moves bytes from the edit to the read queue until the
// edit queue is empty or the read queue is full. Each further echo result (up to nine in all)
// follows when the sink is ready. One item at a time: a new item is taken only in idle.
// Reset: asynchronous active low; queues empty, registers at their documented defaults.
module canonical_line_discipline_unit #(
  parameter int unsigned QUEUE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  cld_stream_if.sink   in_if,
  cld_stream_if.source out_if
);
  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = AW + 1;
  localparam logic [CW-1:0] Full = CW'(QUEUE_DEPTH);

  // Controller states.
  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StRead   = 3'd1; // wait for memory read data
  localparam logic [2:0] StDecide = 3'd2; // data available, act on it
  localparam logic [2:0] StCommit = 3'd3; // move one byte per cycle
  localparam logic [2:0] StEmit   = 3'd4; // present results

  // Pointer steps wrap at the queue depth, which need not be a power of two.
  function automatic logic [AW-1:0] ptr_inc(logic [AW-1:0] p);
    return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(logic [AW-1:0] p);
    return (p == '0) ? AW'(QUEUE_DEPTH - 1) : p - AW'(1);
  endfunction

  logic [3:0]  lflag_q;
  logic [2:0]  iflag_q, oflag_q;
  logic [31:0] spa_q;
  logic [23:0] spb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lflag_q <= 4'd15;
      iflag_q <= 3'd2;
      oflag_q <= 3'd3;
      spa_q   <= 32'h081A1C03;
      spb_q   <= 24'h0A0415;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cld_pkg::CfgLocal:  lflag_q <= cfg_data_i[3:0];
        cld_pkg::CfgInput:  iflag_q <= cfg_data_i[2:0];
        cld_pkg::CfgOutput: oflag_q <= cfg_data_i[2:0];
        cld_pkg::CfgSpecA:  spa_q   <= cfg_data_i;
        cld_pkg::CfgSpecB:  spb_q   <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  logic [2:0]    st_q, st_d;
  logic [AW-1:0] eh_q, eh_d, et_q, et_d, rh_q, rh_d, rt_q, rt_d;
  logic [CW-1:0] ec_q, ec_d, rc_q, rc_d;
  logic          cmd_q;
  logic [7:0]    ch_q, ch_d;
  cld_pkg::echo_t echo_q, echo_d;
  logic [3:0]    idx_q, idx_d;
  logic [1:0]    sig_q, sig_d;
  logic          rdy_q, rdy_d;
  logic [7:0]    rb_q, rb_d;
  logic          rv_q, rv_d, rd_q, rd_d;

  // Memory ports.
  logic          e_we, r_we;
  logic [AW-1:0] e_wa, e_ra, r_wa, r_ra;
  logic [7:0]    e_wd, r_wd, e_rd, r_rd;

  cld_queue_mem #(.Depth(QUEUE_DEPTH)) u_edit (
    .clk_i, .we_i(e_we), .waddr_i(e_wa), .wdata_i(e_wd), .raddr_i(e_ra), .rdata_o(e_rd));
  cld_queue_mem #(.Depth(QUEUE_DEPTH)) u_read (
    .clk_i, .we_i(r_we), .waddr_i(r_wa), .wdata_i(r_wd), .raddr_i(r_ra), .rdata_o(r_rd));

  wire [7:0] sc_int = spa_q[7:0], sc_quit = spa_q[15:8], sc_susp = spa_q[23:16];
  wire [7:0] sc_erase = spa_q[31:24];
  wire [7:0] sc_kill = spb_q[7:0], sc_eof = spb_q[15:8], sc_eol = spb_q[23:16];

  assign in_if.ready = (st_q == StIdle);

  always_comb begin
    logic [7:0] c;
    logic       drop;
    st_d = st_q; eh_d = eh_q; et_d = et_q; rh_d = rh_q; rt_d = rt_q;
    ec_d = ec_q; rc_d = rc_q; ch_d = ch_q; echo_d = echo_q; idx_d = idx_q;
    sig_d = sig_q; rdy_d = rdy_q; rb_d = rb_q; rv_d = rv_q; rd_d = rd_q;
    e_we = 1'b0; e_wa = et_q; e_wd = ch_q; e_ra = ptr_dec(et_q);
    r_we = 1'b0; r_wa = rt_q; r_wd = e_rd; r_ra = rh_q;
    c = ch_q; drop = 1'b0;
    unique case (st_q)
      StIdle: begin
        if (in_if.valid) begin
          ch_d = in_if.data.char_in;
          echo_d = '0; idx_d = '0; sig_d = cld_pkg::SigNone; rdy_d = 1'b0;
          rb_d = '0; rv_d = 1'b0; rd_d = 1'b0;
          st_d = StRead;
        end
      end
      StRead: st_d = StDecide; // read of edit tail-1 and read head in flight
      StDecide: begin
        st_d = StEmit;
        if (cmd_q) begin
          if (rc_q != '0) begin
            rb_d = r_rd; rv_d = 1'b1;
            rd_d = (r_rd == cld_pkg::ChNl) || (r_rd == sc_eof) || (r_rd == sc_eol);
            rh_d = ptr_inc(rh_q);
            rc_d = rc_q - CW'(1);
          end
        end else if (lflag_q[0] && ch_q == sc_int) begin
          sig_d = cld_pkg::SigInt;
        end else if (lflag_q[0] && ch_q == sc_quit) begin
          sig_d = cld_pkg::SigQuit;
        end else if (lflag_q[0] && ch_q == sc_susp) begin
          sig_d = cld_pkg::SigSusp;
        end else if (lflag_q[1]) begin
          if (ch_q == sc_erase) begin
            if (ec_q != '0) begin
              et_d = ptr_dec(et_q);
              ec_d = ec_q - CW'(1);
              if (lflag_q[3]) echo_d = cld_pkg::rubout_echo(e_rd, oflag_q);
            end
          end else if (ch_q == sc_kill) begin
            eh_d = '0; et_d = '0; ec_d = '0;
          end else if (ch_q == sc_eof) begin
            rdy_d = 1'b1;
            st_d = StCommit;
          end else begin
            if (ch_q == cld_pkg::ChCr) begin
              if (iflag_q[0]) drop = 1'b1;
              else if (iflag_q[1]) c = cld_pkg::ChNl;
            end else if (ch_q == cld_pkg::ChNl) begin
              if (iflag_q[2]) c = cld_pkg::ChCr;
            end
            if (!drop) begin
              if (ec_q < Full) begin
                e_we = 1'b1; e_wd = c;
                et_d = ptr_inc(et_q);
                ec_d = ec_q + CW'(1);
              end
              if (lflag_q[2]) echo_d = cld_pkg::echo_char(c, oflag_q);
              if (c == cld_pkg::ChNl || c == sc_eol) begin
                rdy_d = 1'b1;
                st_d = StCommit;
              end
            end
          end
        end else begin
          rdy_d = 1'b1;
          if (rc_q < Full) begin
            r_we = 1'b1; r_wd = ch_q;
            rt_d = ptr_inc(rt_q);
            rc_d = rc_q + CW'(1);
          end
        end
        // Prime the edit head read for a commit; a byte written to the head in
        // this cycle is passed straight through by the memory.
        e_ra = eh_q;
      end
      StCommit: begin
        // e_rd holds edit_store[eh_q]; the read of the next head is issued now.
        if (ec_q != '0 && rc_q < Full) begin
          r_we = 1'b1; r_wd = e_rd;
          rt_d = ptr_inc(rt_q); rc_d = rc_q + CW'(1);
          eh_d = ptr_inc(eh_q); ec_d = ec_q - CW'(1);
          e_ra = ptr_inc(eh_q);
          st_d = StCommit;
        end else begin
          st_d = StEmit;
        end
      end
      StEmit: begin
        if (out_if.ready) begin
          if (idx_q + 4'd1 >= echo_q.len) st_d = StIdle;
          else idx_d = idx_q + 4'd1;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      eh_q <= '0; et_q <= '0; ec_q <= '0;
      rh_q <= '0; rt_q <= '0; rc_q <= '0;
      idx_q <= '0;
    end else begin
      st_q <= st_d;
      eh_q <= eh_d; et_q <= et_d; ec_q <= ec_d;
      rh_q <= rh_d; rt_q <= rt_d; rc_q <= rc_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && in_if.valid) cmd_q <= in_if.data.cmd;
    ch_q <= ch_d; echo_q <= echo_d; sig_q <= sig_d; rdy_q <= rdy_d;
    rb_q <= rb_d; rv_q <= rv_d; rd_q <= rd_d;
  end

  // One result per echo byte, or a single result without echo.
  always_comb begin
    out_if.valid = (st_q == StEmit);
    out_if.data.echo_valid = (echo_q.len != 4'd0);
    out_if.data.echo_byte = (echo_q.len != 4'd0) ? echo_q.bytes[idx_q] : 8'h00;
    out_if.data.signal_code = sig_q;
    out_if.data.line_ready = rdy_q;
    out_if.data.read_byte = rb_q;
    out_if.data.read_valid = rv_q;
    out_if.data.read_delimiter = rd_q;
    out_if.data.queued_count = 9'(rc_q);
    out_if.data.last = (idx_q + 4'd1 >= echo_q.len);
  end
endmodule

>>> src/cld_checker.sv
// Port-level checker for the line discipline unit, bound into the unit module.
// Depends on cld_pkg and the stream interface.
module cld_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input cld_pkg::res_t out_data
);
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready && out_valid)) else $error("input taken while results pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_sig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.signal_code != cld_pkg::SigNone |->
      !out_data.echo_valid && !out_data.line_ready && !out_data.read_valid)
    else $error("signal result carries other effects");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.read_valid |-> out_data.queued_count < 9'd256)
    else $error("count after pop too large");
  a_nolast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_data.echo_valid |-> out_data.last)
    else $error("result without echo not last");
endmodule

bind canonical_line_discipline_unit cld_checker u_cld_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready), .out_data(out_if.data));
